// ===== src/vfq_pkg.sv =====
`timescale 1ns / 1ps
package vfq_pkg;
  localparam int unsigned MaxDim      = 4096;
  localparam int unsigned NdcFracBits = 14;
  localparam int unsigned DimW        = 13;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned DataW       = 32;
  localparam int unsigned QuotW       = 32;
  localparam int unsigned NdcW        = 20;

  localparam logic [IdxW-1:0] RegScreenW = 3'd0;
  localparam logic [IdxW-1:0] RegScreenH = 3'd1;
  localparam logic [IdxW-1:0] RegMode    = 3'd2;
  localparam logic [IdxW-1:0] RegRot     = 3'd3;
  localparam logic [IdxW-1:0] RegOrigin  = 3'd4;
  localparam logic [IdxW-1:0] RegAspN    = 3'd5;
  localparam logic [IdxW-1:0] RegAspD    = 3'd6;

  localparam logic [1:0] ModeNative = 2'd0;
  localparam logic [1:0] ModeFit    = 2'd1;
  localparam logic [1:0] ModeFull   = 2'd2;
  localparam logic [1:0] ModeCrop   = 2'd3;

  typedef struct packed {
    logic [DimW-1:0] sw;
    logic [DimW-1:0] sh;
    logic [1:0]      mode;
    logic [1:0]      rot;
    logic            origin;
    logic [DimW-1:0] an;
    logic [DimW-1:0] ad;
  } cfg_t;

  typedef struct packed {
    logic [DimW-1:0] source_width;
    logic [DimW-1:0] source_height;
  } src_t;

  typedef struct packed {
    logic [1:0]           corner;
    logic signed [NdcW-1:0] pos_x;
    logic signed [NdcW-1:0] pos_y;
    logic                 tex_u;
    logic                 tex_v;
    logic signed [15:0]   rect_x;
    logic signed [15:0]   rect_y;
    logic [15:0]          rect_w;
    logic [15:0]          rect_h;
    logic [DimW-1:0]      phys_width;
    logic [DimW-1:0]      phys_height;
    logic                 last_vertex;
  } vtx_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic one_min);
    logic [DimW-1:0] r;
    r = v;
    if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
    if (one_min && v == '0) r = DimW'(1);
    return r;
  endfunction
endpackage

// ===== src/vfq_if.sv =====
`timescale 1ns / 1ps
interface vfq_src_if;
  logic            valid;
  logic            ready;
  vfq_pkg::src_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vfq_vtx_if;
  logic            valid;
  logic            ready;
  vfq_pkg::vtx_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vfq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [vfq_pkg::IdxW-1:0]   index;
  logic [vfq_pkg::DataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/vfq_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. Unsigned num/den, den > 0.
module vfq_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [vfq_pkg::QuotW-1:0]    num_i,
  input  logic [vfq_pkg::QuotW-1:0]    den_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [vfq_pkg::QuotW-1:0]    quot_o
);
  localparam int unsigned W  = vfq_pkg::QuotW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

// ===== src/vfq_front.sv =====
`timescale 1ns / 1ps
// Classify the source: pick aspect pair, fold the native-mode choices and queue them in a two-entry FIFO.
module vfq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vfq_pkg::cfg_t     cfg_i,
  vfq_src_if.sink           src,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output logic [4*vfq_pkg::DimW-1:0] q_data_o
);
  localparam int unsigned DW = vfq_pkg::DimW;
  logic [DW-1:0] sw, sh, srcw, srch, an, ad, nw, nh;
  logic [1:0][4*DW-1:0] mem_q;
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;
  logic       push, pop;

  always_comb begin
    sw   = vfq_pkg::clamp_dim(cfg_i.sw, 1'b1);
    sh   = vfq_pkg::clamp_dim(cfg_i.sh, 1'b1);
    srcw = vfq_pkg::clamp_dim(src.data.source_width, 1'b0);
    srch = vfq_pkg::clamp_dim(src.data.source_height, 1'b0);
    an   = vfq_pkg::clamp_dim(cfg_i.an, 1'b0);
    ad   = vfq_pkg::clamp_dim(cfg_i.ad, 1'b1);
    if (an == '0) begin
      if (srcw != '0 && srch != '0) begin
        an = srcw;
        ad = srch;
      end else begin
        an = sw;
        ad = sh;
      end
    end
    nw = (srcw != '0) ? srcw : sw;
    nh = (srch != '0) ? srch : sh;
  end

  assign src.ready = (cnt_q != 2'd2);
  assign push      = src.valid && src.ready;
  assign pop       = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= {an, ad, nw, nh};
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("queue lost entry");
endmodule

// ===== src/vfq_back.sv =====
`timescale 1ns / 1ps
// Rectangle fit, then NDC of each edge via a shared divider, then the corner vertices.
module vfq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vfq_pkg::cfg_t     cfg_i,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  logic [4*vfq_pkg::DimW-1:0] q_data_i,
  vfq_vtx_if.source         vtx
);
  localparam int unsigned DW = vfq_pkg::DimW;
  localparam int unsigned QW = vfq_pkg::QuotW;
  localparam int unsigned NW = vfq_pkg::NdcW;
  localparam int unsigned F  = vfq_pkg::NdcFracBits;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StD1   = 4'd1;
  localparam logic [3:0] StW1   = 4'd2;
  localparam logic [3:0] StD2   = 4'd3;
  localparam logic [3:0] StW2   = 4'd4;
  localparam logic [3:0] StOff  = 4'd5;
  localparam logic [3:0] StN    = 4'd6;
  localparam logic [3:0] StNW   = 4'd7;
  localparam logic [3:0] StEmit = 4'd8;

  logic [3:0] st_q, st_d;
  logic [DW-1:0] sw, sh, an_q, ad_q, nw_q, nh_q;
  logic [16:0] w_q, h_q;
  logic signed [17:0] x_q, y_q;
  logic [1:0] ni_q;
  logic [1:0] k_q;
  logic signed [NW:0] ndc_q [4];
  logic signed [19:0] numr [4];
  logic signed [19:0] cur;
  logic [19:0] mag;
  logic [DW-1:0] cur_den;

  logic div_start, div_busy, div_done;
  logic [QW-1:0] div_num, div_den, div_quot;

  vfq_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .done_o(div_done), .quot_o(div_quot)
  );

  assign sw = vfq_pkg::clamp_dim(cfg_i.sw, 1'b1);
  assign sh = vfq_pkg::clamp_dim(cfg_i.sh, 1'b1);

  // edge numerators: x0, x1 over sw; y0, y1 over sh
  always_comb begin
    numr[0] = 20'(2 * x_q) - 20'(sw);
    numr[1] = 20'(2 * (x_q + $signed({1'b0, w_q}))) - 20'(sw);
    numr[2] = 20'(sh) - 20'(2 * (y_q + $signed({1'b0, h_q})));
    numr[3] = 20'(sh) - 20'(2 * y_q);
    cur     = numr[ni_q];
    mag     = cur[19] ? -cur : cur;
    cur_den = ni_q[1] ? sh : sw;
  end

  logic [16:0] sat_q;
  always_comb begin
    sat_q = (div_quot > QW'(65535)) ? 17'd65535 : div_quot[16:0];
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = QW'(1);
    st_d      = st_q;
    case (st_q)
      StIdle: if (q_valid_i) st_d = StD1;
      StD1: begin
        div_start = 1'b1;
        if (cfg_i.mode == vfq_pkg::ModeCrop) begin
          div_num = QW'(sw) * QW'(ad_q);
          div_den = QW'(an_q);
        end else begin
          div_num = QW'(sh) * QW'(an_q);
          div_den = QW'(ad_q);
        end
        st_d = StW1;
      end
      StW1: if (div_done) st_d = StD2;
      StD2: begin
        if (cfg_i.mode == vfq_pkg::ModeFit && w_q > 17'(sw)) begin
          div_start = 1'b1;
          div_num = QW'(sw) * QW'(ad_q);
          div_den = QW'(an_q);
          st_d = StW2;
        end else if (cfg_i.mode == vfq_pkg::ModeCrop && h_q < 17'(sh)) begin
          div_start = 1'b1;
          div_num = QW'(sh) * QW'(an_q);
          div_den = QW'(ad_q);
          st_d = StW2;
        end else begin
          st_d = StOff;
        end
      end
      StW2: if (div_done) st_d = StOff;
      StOff: st_d = StN;
      StN: begin
        div_start = 1'b1;
        div_num = QW'({mag, 1'b0, F'(0)}) + QW'(cur_den);
        div_den = QW'({cur_den, 1'b0});
        st_d = StNW;
      end
      StNW: if (div_done) st_d = (ni_q == 2'd3) ? StEmit : StN;
      StEmit: if (vtx.ready && k_q == 2'd3) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign q_ready_o = (st_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ni_q <= '0;
      k_q  <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StOff) ni_q <= '0;
      else if (st_q == StNW && div_done) ni_q <= ni_q + 2'd1;
      if (st_q == StEmit && vtx.ready) k_q <= k_q + 2'd1;
    end
  end

  // Keep the magnitude clamped at 2^19 with its sign, so that a rotation can
  // negate it exactly before the final saturation.
  logic [NW-1:0] qmag;
  logic signed [NW:0] ndc_val;
  always_comb begin
    qmag = (div_quot > QW'(2**(NW-1))) ? NW'(2**(NW-1)) : div_quot[NW-1:0];
    ndc_val = cur[19] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_valid_i) begin
      {an_q, ad_q, nw_q, nh_q} <= q_data_i;
    end
    if (st_q == StW1 && div_done) begin
      if (cfg_i.mode == vfq_pkg::ModeCrop) begin
        w_q <= 17'(sw);
        h_q <= sat_q;
      end else if (cfg_i.mode == vfq_pkg::ModeFit) begin
        w_q <= sat_q;
        h_q <= 17'(sh);
      end else if (cfg_i.mode == vfq_pkg::ModeNative) begin
        w_q <= 17'(nw_q);
        h_q <= 17'(nh_q);
      end else begin
        w_q <= 17'(sw);
        h_q <= 17'(sh);
      end
    end
    if (st_q == StW2 && div_done) begin
      if (cfg_i.mode == vfq_pkg::ModeFit) begin
        w_q <= 17'(sw);
        h_q <= sat_q;
      end else begin
        w_q <= sat_q;
        h_q <= 17'(sh);
      end
    end
    if (st_q == StOff) begin
      if (cfg_i.mode == vfq_pkg::ModeFull) begin
        x_q <= '0;
        y_q <= '0;
      end else begin
        // truncate toward zero
        x_q <= ($signed(18'(sw)) - $signed({1'b0, w_q})) / 18'sd2;
        y_q <= ($signed(18'(sh)) - $signed({1'b0, h_q})) / 18'sd2;
      end
    end
    if (st_q == StNW && div_done) ndc_q[ni_q] <= ndc_val;
  end

  logic signed [NW:0] lx, ly;
  logic signed [NW-1:0] px, py;
  logic [NW-1:0] neg_max;
  assign neg_max = {1'b1, {(NW-1){1'b0}}};

  function automatic logic signed [NW-1:0] sat_ndc(input logic signed [NW:0] v);
    return (v > $signed({2'b00, {(NW-1){1'b1}}})) ? $signed({1'b0, {(NW-1){1'b1}}})
                                                   : v[NW-1:0];
  endfunction

  always_comb begin
    lx = ndc_q[{1'b0, k_q[0]}];
    ly = ndc_q[{1'b1, k_q[1]}];
    case (cfg_i.rot)
      2'd1: begin px = sat_ndc(ly);  py = sat_ndc(-lx); end
      2'd2: begin px = sat_ndc(-lx); py = sat_ndc(-ly); end
      2'd3: begin px = sat_ndc(-ly); py = sat_ndc(lx);  end
      default: begin px = sat_ndc(lx); py = sat_ndc(ly); end
    endcase
  end

  always_comb begin
    vtx.valid            = (st_q == StEmit);
    vtx.data.corner      = k_q;
    vtx.data.pos_x       = px;
    vtx.data.pos_y       = py;
    vtx.data.tex_u       = k_q[0];
    vtx.data.tex_v       = k_q[1] ? cfg_i.origin : ~cfg_i.origin;
    vtx.data.rect_x      = 16'(x_q);
    vtx.data.rect_y      = 16'(y_q);
    vtx.data.rect_w      = w_q[15:0];
    vtx.data.rect_h      = h_q[15:0];
    vtx.data.phys_width  = cfg_i.rot[0] ? sh : sw;
    vtx.data.phys_height = cfg_i.rot[0] ? sw : sh;
    vtx.data.last_vertex = (k_q == 2'd3);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vtx.valid && vtx.ready && vtx.data.last_vertex) |=> st_q == StIdle)
    else $error("item did not close after last vertex");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StEmit) |-> (k_q == 2'd0)) else $error("corner count stray");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    neg_max[NW-1]) else $error("bad constant");
endmodule

// ===== src/viewport_fit_and_quad.sv =====
`timescale 1ns / 1ps
// Fits a source frame into the screen and emits four quad vertices per item.
// Every divide holds the shared bit-serial divider until it is done: one or two
// rectangle divides and four NDC divides per item. The four vertex transfers
// then go out at one per cycle while the receiver is ready; output stalls
// hold them. A two-entry queue lets the next source size be accepted while
// the current item is in work.
module viewport_fit_and_quad (
  input  logic      clk_i,
  input  logic      rst_ni,
  vfq_cfg_if.sink   cfg,
  vfq_src_if.sink   src,
  vfq_vtx_if.source vtx
);
  vfq_pkg::cfg_t cfg_q;
  logic q_valid, q_ready;
  logic [4*vfq_pkg::DimW-1:0] q_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sw     <= 13'd640;
      cfg_q.sh     <= 13'd480;
      cfg_q.mode   <= vfq_pkg::ModeFit;
      cfg_q.rot    <= 2'd0;
      cfg_q.origin <= 1'b0;
      cfg_q.an     <= '0;
      cfg_q.ad     <= 13'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        vfq_pkg::RegScreenW: cfg_q.sw     <= cfg.data[12:0];
        vfq_pkg::RegScreenH: cfg_q.sh     <= cfg.data[12:0];
        vfq_pkg::RegMode:    cfg_q.mode   <= cfg.data[1:0];
        vfq_pkg::RegRot:     cfg_q.rot    <= cfg.data[1:0];
        vfq_pkg::RegOrigin:  cfg_q.origin <= cfg.data[0];
        vfq_pkg::RegAspN:    cfg_q.an     <= cfg.data[12:0];
        vfq_pkg::RegAspD:    cfg_q.ad     <= cfg.data[12:0];
        default: ;
      endcase
    end
  end

  vfq_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .src,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  vfq_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data), .vtx
  );
endmodule

// ===== sim/viewport_fit_and_quad_test.sv =====
`timescale 1ns / 1ps
module viewport_fit_and_quad_test;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 250;
  localparam int HoldCycles = 1500;

  typedef struct {
    vfq_pkg::cfg_t c;
    vfq_pkg::src_t s;
    bit          typed;
    logic [15:0] rx, ry, rw, rh;
  } vec_t;

  logic clk_i;
  logic rst_ni;

  vfq_cfg_if cfg_bus ();
  vfq_src_if src_bus ();
  vfq_vtx_if vtx_bus ();

  viewport_fit_and_quad dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_bus),
    .src    (src_bus),
    .vtx    (vtx_bus)
  );

  vfq_pkg::cfg_t shadow;
  vfq_pkg::vtx_t vertex_q[$];
  vec_t  vectors[$];
  int    errors = 0;
  int    src_idle = 0;
  int    snk_idle = 0;
  int    hold_req = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  longint cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("viewport_fit_and_quad test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic longint lim_dim(input longint v, input longint lo);
    if (v > vfq_pkg::MaxDim) return vfq_pkg::MaxDim;
    if (v < lo) return lo;
    return v;
  endfunction

  // Round num/den * 2^F to nearest, ties away from zero, then saturate.
  function automatic logic [vfq_pkg::NdcW-1:0] ndc_of(input longint num, input longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (2 * (mag <<< vfq_pkg::NdcFracBits) + den) / (2 * den);
    if (num < 0) begin
      if (q > 524288) q = 524288;
      return vfq_pkg::NdcW'(-q);
    end
    if (q > 524287) q = 524287;
    return vfq_pkg::NdcW'(q);
  endfunction

  function automatic void predict_quad(input vfq_pkg::src_t s, input vec_t row);
    longint sw, sh, srcw, srch, an, ad, x, y, w, h;
    longint nx[2], ny[2];
    longint lx, ly;
    vfq_pkg::vtx_t v;
    sw = lim_dim(shadow.sw, 1);
    sh = lim_dim(shadow.sh, 1);
    srcw = lim_dim(s.source_width, 0);
    srch = lim_dim(s.source_height, 0);
    an = lim_dim(shadow.an, 0);
    ad = lim_dim(shadow.ad, 1);
    x = 0;
    y = 0;
    w = sw;
    h = sh;
    if (an == 0) begin
      if (srcw > 0 && srch > 0) begin
        an = srcw;
        ad = srch;
      end else begin
        an = sw;
        ad = sh;
      end
    end
    case (shadow.mode)
      vfq_pkg::ModeFit: begin
        h = sh;
        w = sh * an / ad;
        if (w > sw) begin
          w = sw;
          h = sw * ad / an;
        end
      end
      vfq_pkg::ModeNative: begin
        w = (srcw > 0) ? srcw : sw;
        h = (srch > 0) ? srch : sh;
      end
      vfq_pkg::ModeCrop: begin
        w = sw;
        h = sw * ad / an;
        if (h < sh) begin
          h = sh;
          w = sh * an / ad;
        end
      end
      default: ;
    endcase
    if (w > 65535) w = 65535;
    if (h > 65535) h = 65535;
    if (shadow.mode != vfq_pkg::ModeFull) begin
      x = (sw - w) / 2;
      y = (sh - h) / 2;
    end
    nx[0] = 2 * x - sw;
    nx[1] = 2 * (x + w) - sw;
    ny[0] = sh - 2 * (y + h);
    ny[1] = sh - 2 * y;
    for (int k = 0; k < 4; k++) begin
      lx = nx[k & 1];
      ly = ny[k >> 1];
      case (shadow.rot)
        2'd1: begin v.pos_x = ndc_of(ly, sh); v.pos_y = ndc_of(-lx, sw); end
        2'd2: begin v.pos_x = ndc_of(-lx, sw); v.pos_y = ndc_of(-ly, sh); end
        2'd3: begin v.pos_x = ndc_of(-ly, sh); v.pos_y = ndc_of(lx, sw); end
        default: begin v.pos_x = ndc_of(lx, sw); v.pos_y = ndc_of(ly, sh); end
      endcase
      v.corner = 2'(k);
      v.tex_u = k[0];
      v.tex_v = (k < 2) ? ~shadow.origin : shadow.origin;
      v.rect_x = row.typed ? row.rx : 16'(x);
      v.rect_y = row.typed ? row.ry : 16'(y);
      v.rect_w = row.typed ? row.rw : 16'(w);
      v.rect_h = row.typed ? row.rh : 16'(h);
      if (shadow.rot[0]) begin
        v.phys_width = vfq_pkg::DimW'(sh);
        v.phys_height = vfq_pkg::DimW'(sw);
      end else begin
        v.phys_width = vfq_pkg::DimW'(sw);
        v.phys_height = vfq_pkg::DimW'(sh);
      end
      v.last_vertex = (k == 3);
      vertex_q.push_back(v);
    end
  endfunction

  always @(posedge clk_i) begin
    vfq_pkg::vtx_t got, want;
    if (rst_ni && vtx_bus.valid && vtx_bus.ready) begin
      got = vtx_bus.data;
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected vertex, corner", got.corner, -1);
      end else begin
        want = vertex_q.pop_front();
        if (got.corner !== want.corner) report_mismatch("corner", got.corner, want.corner);
        if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
        if (got.tex_u !== want.tex_u) report_mismatch("tex_u", got.tex_u, want.tex_u);
        if (got.tex_v !== want.tex_v) report_mismatch("tex_v", got.tex_v, want.tex_v);
        if (got.rect_x !== want.rect_x) report_mismatch("rect_x", got.rect_x, want.rect_x);
        if (got.rect_y !== want.rect_y) report_mismatch("rect_y", got.rect_y, want.rect_y);
        if (got.rect_w !== want.rect_w) report_mismatch("rect_w", got.rect_w, want.rect_w);
        if (got.rect_h !== want.rect_h) report_mismatch("rect_h", got.rect_h, want.rect_h);
        if (got.phys_width !== want.phys_width)
          report_mismatch("phys_width", got.phys_width, want.phys_width);
        if (got.phys_height !== want.phys_height)
          report_mismatch("phys_height", got.phys_height, want.phys_height);
        if (got.last_vertex !== want.last_vertex)
          report_mismatch("last_vertex", got.last_vertex, want.last_vertex);
      end
    end
  end

  // Receiver: a requested hold stalls it outright, otherwise stall at random.
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      vtx_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      vtx_bus.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic write_reg(input logic [vfq_pkg::IdxW-1:0] idx,
                           input logic [vfq_pkg::DataW-1:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      vfq_pkg::RegScreenW: shadow.sw = val[vfq_pkg::DimW-1:0];
      vfq_pkg::RegScreenH: shadow.sh = val[vfq_pkg::DimW-1:0];
      vfq_pkg::RegMode:    shadow.mode = val[1:0];
      vfq_pkg::RegRot:     shadow.rot = val[1:0];
      vfq_pkg::RegOrigin:  shadow.origin = val[0];
      vfq_pkg::RegAspN:    shadow.an = val[vfq_pkg::DimW-1:0];
      vfq_pkg::RegAspD:    shadow.ad = val[vfq_pkg::DimW-1:0];
      default: ;
    endcase
    @(negedge clk_i) cfg_bus.valid <= 1'b0;
  endtask

  // Drop the source valid and let the block run dry.
  task automatic drain();
    @(negedge clk_i) src_bus.valid <= 1'b0;
    wait (vertex_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_cfg(input vfq_pkg::cfg_t c);
    drain();
    write_reg(vfq_pkg::RegScreenW, vfq_pkg::DataW'(c.sw));
    write_reg(vfq_pkg::RegScreenH, vfq_pkg::DataW'(c.sh));
    write_reg(vfq_pkg::RegMode, vfq_pkg::DataW'(c.mode));
    write_reg(vfq_pkg::RegRot, vfq_pkg::DataW'(c.rot));
    write_reg(vfq_pkg::RegOrigin, vfq_pkg::DataW'(c.origin));
    write_reg(vfq_pkg::RegAspN, vfq_pkg::DataW'(c.an));
    write_reg(vfq_pkg::RegAspD, vfq_pkg::DataW'(c.ad));
  endtask

  task automatic send_src(input vfq_pkg::src_t s, input vec_t row);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      src_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    src_bus.valid <= 1'b1;
    src_bus.data <= s;
    do @(posedge clk_i); while (!src_bus.ready);
    predict_quad(s, row);
  endtask

  function automatic logic [vfq_pkg::DimW-1:0] rand_dim(input int lo);
    case ($urandom_range(19))
      0: return vfq_pkg::DimW'(lo);
      1: return vfq_pkg::DimW'(vfq_pkg::MaxDim);
      2: return vfq_pkg::DimW'($urandom_range(8191));
      3, 4, 5: return vfq_pkg::DimW'($urandom_range(64, lo));
      default: return vfq_pkg::DimW'($urandom_range(vfq_pkg::MaxDim, lo));
    endcase
  endfunction

  function automatic vfq_pkg::cfg_t rand_cfg();
    vfq_pkg::cfg_t c;
    c.sw = rand_dim(1);
    c.sh = rand_dim(1);
    c.mode = 2'($urandom_range(3));
    c.rot = 2'($urandom_range(3));
    c.origin = 1'($urandom_range(1));
    c.an = ($urandom_range(2) == 0) ? rand_dim(1) : '0;
    c.ad = rand_dim(1);
    return c;
  endfunction

  function automatic vfq_pkg::src_t rand_src();
    vfq_pkg::src_t s;
    s.source_width = ($urandom_range(9) == 0) ? '0 : rand_dim(1);
    s.source_height = ($urandom_range(9) == 0) ? '0 : rand_dim(1);
    return s;
  endfunction

  task automatic add_vec(input vfq_pkg::cfg_t c, input int sw, input int sh, input bit typed,
                         input int rx, input int ry, input int rw, input int rh);
    vec_t r;
    r.c = c;
    r.s.source_width = vfq_pkg::DimW'(sw);
    r.s.source_height = vfq_pkg::DimW'(sh);
    r.typed = typed;
    r.rx = 16'(rx);
    r.ry = 16'(ry);
    r.rw = 16'(rw);
    r.rh = 16'(rh);
    vectors.push_back(r);
  endtask

  initial begin
    vfq_pkg::cfg_t rst_cfg, c;
    vec_t plain;
    int   idle_src[3] = '{24, 62, 0};
    int   idle_snk[3] = '{62, 24, 0};
    plain.typed = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    src_bus.valid = 1'b0;
    src_bus.data = '0;
    rst_cfg = '{sw: 13'd640, sh: 13'd480, mode: vfq_pkg::ModeFit, rot: 2'd0,
                origin: 1'b0, an: 13'd0, ad: 13'd1};
    shadow = rst_cfg;

    add_vec(rst_cfg, 0, 0, 1, 0, 0, 640, 480);
    add_vec(rst_cfg, 1920, 1080, 1, 0, 60, 640, 360);
    add_vec(rst_cfg, 4096, 1, 1, 0, 240, 640, 0);
    add_vec(rst_cfg, 1, 4096, 1, 320, 0, 0, 480);
    c = rst_cfg; c.mode = vfq_pkg::ModeFull;
    add_vec(c, 8191, 8191, 1, 0, 0, 640, 480);
    c.mode = vfq_pkg::ModeNative;
    add_vec(c, 4096, 4096, 1, -1728, -1808, 4096, 4096);
    add_vec(c, 0, 0, 1, 0, 0, 640, 480);
    add_vec(c, 8191, 0, 1, -1728, 0, 4096, 480);
    c.mode = vfq_pkg::ModeCrop;
    add_vec(c, 1920, 1080, 1, -106, 0, 853, 480);
    c = '{sw: 13'd640, sh: 13'd480, mode: vfq_pkg::ModeFit, rot: 2'd1, origin: 1'b1,
          an: 13'd4, ad: 13'd3};
    add_vec(c, 100, 100, 0, 0, 0, 0, 0);
    c.rot = 2'd2;
    add_vec(c, 100, 100, 0, 0, 0, 0, 0);
    c.rot = 2'd3;
    add_vec(c, 300, 7, 0, 0, 0, 0, 0);
    c = '{sw: 13'd1, sh: 13'd1, mode: vfq_pkg::ModeFit, rot: 2'd0, origin: 1'b0,
          an: 13'd4096, ad: 13'd1};
    add_vec(c, 5, 5, 0, 0, 0, 0, 0);
    c = '{sw: 13'd4096, sh: 13'd4096, mode: vfq_pkg::ModeCrop, rot: 2'd0, origin: 1'b0,
          an: 13'd1, ad: 13'd4096};
    add_vec(c, 5, 5, 1, 0, -30719, 4096, 65535);
    c = '{sw: 13'd8191, sh: 13'd0, mode: vfq_pkg::ModeFull, rot: 2'd1, origin: 1'b0,
          an: 13'd0, ad: 13'd1};
    add_vec(c, 0, 7, 0, 0, 0, 0, 0);
    c = '{sw: 13'd640, sh: 13'd480, mode: vfq_pkg::ModeFit, rot: 2'd0, origin: 1'b0,
          an: 13'd8191, ad: 13'd0};
    add_vec(c, 9, 9, 0, 0, 0, 0, 0);
    c = '{sw: 13'd1, sh: 13'd1, mode: vfq_pkg::ModeCrop, rot: 2'd3, origin: 1'b1,
          an: 13'd1, ad: 13'd4096};
    add_vec(c, 9, 9, 0, 0, 0, 0, 0);
    c = '{sw: 13'd1, sh: 13'd1, mode: vfq_pkg::ModeNative, rot: 2'd2, origin: 1'b0,
          an: 13'd0, ad: 13'd1};
    add_vec(c, 4096, 4096, 0, 0, 0, 0, 0);
    add_vec(c, 8191, 1, 0, 0, 0, 0, 0);

    wait (rst_ni === 1'b1);
    foreach (vectors[i]) begin
      if (vectors[i].c != shadow) load_cfg(vectors[i].c);
      send_src(vectors[i].s, vectors[i]);
    end

    for (int p = 0; p < 3; p++) begin
      for (int n = 0; n < 148; n++) begin
        if (n % 37 == 0) begin
          load_cfg(rand_cfg());
          src_idle = idle_src[p];
          snk_idle = idle_snk[p];
          // Long receiver stall so the input queue fills up.
          if (p == 0 && n == 0) hold_req = hold_req + 1;
        end
        send_src(rand_src(), plain);
      end
    end

    drain();
    if (errors == 0) begin
      $display("viewport_fit_and_quad test passed");
    end else begin
      $display("viewport_fit_and_quad test failed");
    end
    $finish;
  end
endmodule
